// File: rtl/ssg_pkg.sv
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types, widths and codes for the spiral scan generator.
// ----------------------------------------------------------------------------
package ssg_pkg;

  // Field and state widths
  localparam int DIM_W  = 6;
  localparam int POS_W  = 6;
  localparam int ROW_W  = 5;
  localparam int NUM_W  = 11;
  localparam int SQ_W   = 2 * DIM_W;
  localparam int DIR_W  = 2;
  localparam int TURN_W = 2;
  localparam int CFG_IDX_W = 2;

  // Default largest grid side
  localparam int MAX_DIM_DEF = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DIR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION  = 2'd2;

  // Headings
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

  // Rotation senses
  localparam logic ROT_CW  = 1'b0;
  localparam logic ROT_CCW = 1'b1;

  // Turns per run length
  localparam logic [TURN_W-1:0] TURNS_PER_RUN = 2'd2;

  // Walk state carried between requests
  typedef struct packed {
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [NUM_W-1:0]  number;
    logic [DIM_W-1:0]  run_length;
    logic [DIM_W-1:0]  steps_left;
    logic [TURN_W-1:0] turns_left;
    logic [DIR_W-1:0]  heading;
    logic              active;
    logic              rot;
    logic [SQ_W-1:0]   dim_sq;
  } walk_t;

  // Result of one request
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [NUM_W-1:0] number;
    logic             last;
  } result_t;

  // Offsets of the start cell below the grid half for an even side,
  // packed as {row_ofs, col_ofs}
  function automatic logic [1:0] start_ofs(input logic rot, input logic [DIR_W-1:0] dir);
    logic [1:0] ofs;
    ofs = 2'b00;
    if (rot == ROT_CW) begin
      case (dir)
        DIR_UP:    ofs = 2'b01;
        DIR_RIGHT: ofs = 2'b11;
        DIR_DOWN:  ofs = 2'b10;
        DIR_LEFT:  ofs = 2'b00;
        default:   ofs = 2'b00;
      endcase
    end else begin
      case (dir)
        DIR_UP:    ofs = 2'b00;
        DIR_RIGHT: ofs = 2'b01;
        DIR_DOWN:  ofs = 2'b11;
        DIR_LEFT:  ofs = 2'b10;
        default:   ofs = 2'b00;
      endcase
    end
    return ofs;
  endfunction

endpackage

// File: rtl/ssg_step.sv
// ----------------------------------------------------------------------------
// ssg_step
// Next-cell logic: picks the start cell on restart, forms the result and
// advances the walk state by one cell.
// ----------------------------------------------------------------------------
module ssg_step #(
  parameter int MAX_DIM = ssg_pkg::MAX_DIM_DEF
) (
  input  ssg_pkg::walk_t                   walk_i,
  input  logic                             restart_i,
  input  logic [ssg_pkg::DIM_W-1:0]        cfg_dim_i,
  input  logic [ssg_pkg::DIR_W-1:0]        cfg_dir_i,
  input  logic                             cfg_rot_i,
  output ssg_pkg::walk_t                   walk_o,
  output ssg_pkg::result_t                 result_o,
  output logic                             emit_o
);

  localparam logic [ssg_pkg::DIM_W:0] DIM_LIM = (ssg_pkg::DIM_W + 1)'(MAX_DIM);

  logic [ssg_pkg::DIM_W-1:0] n;
  logic [ssg_pkg::DIM_W-1:0] half;
  logic [1:0]                ofs;
  ssg_pkg::walk_t            start;
  ssg_pkg::walk_t            cur;
  ssg_pkg::walk_t            nxt;
  logic                      is_last;

  // Clamp the side and build the start state
  always_comb begin
    n = cfg_dim_i;
    if (n == '0) begin
      n = ssg_pkg::DIM_W'(1);
    end else if ({1'b0, n} > DIM_LIM) begin
      n = DIM_LIM[ssg_pkg::DIM_W-1:0];
    end
    half = n >> 1;
    ofs  = ssg_pkg::start_ofs(cfg_rot_i, cfg_dir_i);

    start            = walk_i;
    start.row        = n[0] ? half : half - ssg_pkg::DIM_W'(ofs[1]);
    start.col        = n[0] ? half : half - ssg_pkg::DIM_W'(ofs[0]);
    start.number     = ssg_pkg::NUM_W'(1);
    start.run_length = ssg_pkg::DIM_W'(1);
    start.steps_left = ssg_pkg::DIM_W'(1);
    start.turns_left = ssg_pkg::TURNS_PER_RUN;
    start.heading    = cfg_dir_i;
    start.active     = 1'b1;
    start.rot        = cfg_rot_i;
    start.dim_sq     = ssg_pkg::SQ_W'(n) * ssg_pkg::SQ_W'(n);
  end

  // Emit the current cell and step to the next one
  always_comb begin
    cur     = restart_i ? start : walk_i;
    is_last = ({1'b0, cur.number} == cur.dim_sq);
    nxt     = cur;
    if (cur.active) begin
      if (is_last) begin
        nxt.active = 1'b0;
      end else begin
        case (cur.heading)
          ssg_pkg::DIR_UP:    nxt.row = cur.row - ssg_pkg::POS_W'(1);
          ssg_pkg::DIR_RIGHT: nxt.col = cur.col + ssg_pkg::POS_W'(1);
          ssg_pkg::DIR_DOWN:  nxt.row = cur.row + ssg_pkg::POS_W'(1);
          default:            nxt.col = cur.col - ssg_pkg::POS_W'(1);
        endcase
        nxt.number = cur.number + ssg_pkg::NUM_W'(1);
        if (cur.steps_left == ssg_pkg::DIM_W'(1)) begin
          // end of a run: turn, and lengthen every second run
          if (cur.turns_left == ssg_pkg::TURN_W'(1)) begin
            nxt.run_length = cur.run_length + ssg_pkg::DIM_W'(1);
            nxt.turns_left = ssg_pkg::TURNS_PER_RUN;
          end else begin
            nxt.turns_left = cur.turns_left - ssg_pkg::TURN_W'(1);
          end
          nxt.steps_left = nxt.run_length;
          nxt.heading    = (cur.rot == ssg_pkg::ROT_CCW) ? cur.heading - ssg_pkg::DIR_W'(1)
                                                         : cur.heading + ssg_pkg::DIR_W'(1);
        end else begin
          nxt.steps_left = cur.steps_left - ssg_pkg::DIM_W'(1);
        end
      end
    end
  end

  assign walk_o          = nxt;
  assign emit_o          = cur.active;
  assign result_o.row    = cur.row[ssg_pkg::ROW_W-1:0];
  assign result_o.col    = cur.col[ssg_pkg::ROW_W-1:0];
  assign result_o.number = cur.number;
  assign result_o.last   = is_last;

endmodule

// File: rtl/spiral_scan_generator_top.sv
// ----------------------------------------------------------------------------
// spiral_scan_generator_top
// Square spiral address generator walking an N by N grid from its centre.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_restart
//   out      output     out_valid/out_stall out_row, out_col, out_number, out_last
//   cfg      input      cfg_we              cfg_index, cfg_wdata
//
// One request per clock while in_stall is low; a result appears in the cycle after
// its request is taken. The walk state register is the only loop: start selection,
// step and last check all sit in combinational logic ahead of the result register.
// Reset (synchronous, rst_n low) leaves the walk idle: advances give nothing
// until a restart. A held result stalls input only while out_stall is high.
// ----------------------------------------------------------------------------
module spiral_scan_generator_top #(
  parameter int MAX_DIM = ssg_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ssg_pkg::ROW_W-1:0]         out_row,
  output logic [ssg_pkg::ROW_W-1:0]         out_col,
  output logic [ssg_pkg::NUM_W-1:0]         out_number,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [ssg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssg_pkg::DIM_W-1:0]         cfg_wdata
);

  logic [ssg_pkg::DIM_W-1:0] dim_r;
  logic [ssg_pkg::DIR_W-1:0] dir_r;
  logic                      rot_r;
  ssg_pkg::walk_t            walk_r;
  ssg_pkg::walk_t            walk_nxt;
  ssg_pkg::result_t          res_nxt;
  ssg_pkg::result_t          res_r;
  logic                      emit;
  logic                      out_valid_r;
  logic                      in_acc;

  // Take a request whenever the result slot is free or being emptied
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= ssg_pkg::DIM_W'(1);
      dir_r <= ssg_pkg::DIR_UP;
      rot_r <= ssg_pkg::ROT_CW;
    end else if (cfg_we) begin
      case (cfg_index)
        ssg_pkg::CFG_DIMENSION: dim_r <= cfg_wdata;
        ssg_pkg::CFG_START_DIR: dir_r <= cfg_wdata[ssg_pkg::DIR_W-1:0];
        ssg_pkg::CFG_ROTATION:  rot_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  ssg_step #(
    .MAX_DIM (MAX_DIM)
  ) u_step (
    .walk_i    (walk_r),
    .restart_i (in_restart),
    .cfg_dim_i (dim_r),
    .cfg_dir_i (dir_r),
    .cfg_rot_i (rot_r),
    .walk_o    (walk_nxt),
    .result_o  (res_nxt),
    .emit_o    (emit)
  );

  // Advance the walk on each taken request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r.row        <= '0;
      walk_r.col        <= '0;
      walk_r.number     <= '0;
      walk_r.run_length <= ssg_pkg::DIM_W'(1);
      walk_r.steps_left <= ssg_pkg::DIM_W'(1);
      walk_r.turns_left <= ssg_pkg::TURNS_PER_RUN;
      walk_r.heading    <= ssg_pkg::DIR_UP;
      walk_r.active     <= 1'b0;
      walk_r.rot        <= ssg_pkg::ROT_CW;
      walk_r.dim_sq     <= ssg_pkg::SQ_W'(1);
    end else if (in_acc) begin
      walk_r <= walk_nxt;
    end
  end

  // Result register: load on a taken request, drop once delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_row    = res_r.row;
  assign out_col    = res_r.col;
  assign out_number = res_r.number;
  assign out_last   = res_r.last;

  // A restart always yields cell number one next cycle
  a_restart_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_restart) |=> (out_valid && out_number == ssg_pkg::NUM_W'(1)))
    else $error("restart did not emit cell one");

  // An advance on an idle walk yields nothing
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_restart && !walk_r.active) |=> !out_valid)
    else $error("idle walk produced a result");

  // Steps left in a run stay within the run length
  a_steps_range: assert property (@(posedge clk) disable iff (!rst_n)
    walk_r.active |-> (walk_r.steps_left != '0 && walk_r.steps_left <= walk_r.run_length))
    else $error("steps left outside run length");

  // The last cell closes the walk
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit && res_nxt.last) |=> !walk_r.active)
    else $error("walk still active after last cell");

endmodule

// File: verif/spiral_walk_checker.sv
// ----------------------------------------------------------------------------
// spiral_walk_checker
// Tracks the spiral walk beside the generator and checks every cell it emits.
//
// Keeps its own copy of the configuration registers and of the walk state.
// Each accepted request is stepped through that copy, and the cell it gives,
// if any, is queued. Each accepted result is checked field by field against
// the oldest queued cell. Mismatches, results that arrive with nothing queued
// and the number of cells still owed are reported to the testbench top.
// ----------------------------------------------------------------------------
module spiral_walk_checker #(
  parameter int MAX_DIM = ssg_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_restart,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [ssg_pkg::ROW_W-1:0]     out_row,
  input  logic [ssg_pkg::ROW_W-1:0]     out_col,
  input  logic [ssg_pkg::NUM_W-1:0]     out_number,
  input  logic                          out_last,
  input  logic                          cfg_we,
  input  logic [ssg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssg_pkg::DIM_W-1:0]     cfg_wdata,
  output int                            mismatches,
  output int                            cells_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies
  logic [ssg_pkg::DIM_W-1:0]  side_reg;
  logic [ssg_pkg::DIR_W-1:0]  start_dir_reg;
  logic                       rot_reg;

  // Walk copy: next cell to emit and the run bookkeeping
  logic [ssg_pkg::POS_W-1:0]  walk_row;
  logic [ssg_pkg::POS_W-1:0]  walk_col;
  logic [ssg_pkg::NUM_W-1:0]  walk_number;
  logic [ssg_pkg::DIM_W-1:0]  walk_run;
  logic [ssg_pkg::DIM_W-1:0]  walk_steps;
  logic [ssg_pkg::TURN_W-1:0] walk_turns;
  logic [ssg_pkg::DIR_W-1:0]  walk_heading;
  logic                       walk_on;
  logic                       walk_rot;
  logic [ssg_pkg::SQ_W-1:0]   walk_cells;

  ssg_pkg::result_t due_cells[$];

  // Place the walk on its start cell; side and rotation are latched here
  task automatic begin_spiral();
    int                        side;
    logic [ssg_pkg::POS_W-1:0] half;
    side = int'(side_reg);
    if (side < 1) side = 1;
    if (side > MAX_DIM) side = MAX_DIM;
    walk_cells = ssg_pkg::SQ_W'(side * side);
    walk_rot   = rot_reg;
    half       = ssg_pkg::POS_W'(side / 2);
    if (side % 2 != 0) begin
      walk_row = ssg_pkg::POS_W'((side - 1) / 2);
      walk_col = ssg_pkg::POS_W'((side - 1) / 2);
    end else if (walk_rot == ssg_pkg::ROT_CW) begin
      case (start_dir_reg)
        ssg_pkg::DIR_UP: begin
          walk_row = half;
          walk_col = half - ssg_pkg::POS_W'(1);
        end
        ssg_pkg::DIR_RIGHT: begin
          walk_row = half - ssg_pkg::POS_W'(1);
          walk_col = half - ssg_pkg::POS_W'(1);
        end
        ssg_pkg::DIR_DOWN: begin
          walk_row = half - ssg_pkg::POS_W'(1);
          walk_col = half;
        end
        default: begin
          walk_row = half;
          walk_col = half;
        end
      endcase
    end else begin
      case (start_dir_reg)
        ssg_pkg::DIR_UP: begin
          walk_row = half;
          walk_col = half;
        end
        ssg_pkg::DIR_RIGHT: begin
          walk_row = half;
          walk_col = half - ssg_pkg::POS_W'(1);
        end
        ssg_pkg::DIR_DOWN: begin
          walk_row = half - ssg_pkg::POS_W'(1);
          walk_col = half - ssg_pkg::POS_W'(1);
        end
        default: begin
          walk_row = half - ssg_pkg::POS_W'(1);
          walk_col = half;
        end
      endcase
    end
    walk_heading = start_dir_reg;
    walk_number  = ssg_pkg::NUM_W'(1);
    walk_run     = ssg_pkg::DIM_W'(1);
    walk_steps   = ssg_pkg::DIM_W'(1);
    walk_turns   = ssg_pkg::TURNS_PER_RUN;
    walk_on      = 1'b1;
  endtask

  // Step the walk for one request and give the cell it emits, if any
  task automatic spiral_step(input logic restart_bit, output bit emitted,
                             output ssg_pkg::result_t res);
    if (restart_bit) begin_spiral();
    emitted = walk_on;
    res     = '0;
    if (walk_on) begin
      res.row    = walk_row[ssg_pkg::ROW_W-1:0];
      res.col    = walk_col[ssg_pkg::ROW_W-1:0];
      res.number = walk_number;
      res.last   = ({1'b0, walk_number} == walk_cells);
      if (res.last) begin
        walk_on = 1'b0;
      end else begin
        case (walk_heading)
          ssg_pkg::DIR_UP:    walk_row = walk_row - ssg_pkg::POS_W'(1);
          ssg_pkg::DIR_RIGHT: walk_col = walk_col + ssg_pkg::POS_W'(1);
          ssg_pkg::DIR_DOWN:  walk_row = walk_row + ssg_pkg::POS_W'(1);
          default:            walk_col = walk_col - ssg_pkg::POS_W'(1);
        endcase
        walk_number = walk_number + ssg_pkg::NUM_W'(1);
        walk_steps  = walk_steps - ssg_pkg::DIM_W'(1);
        // End of a run: turn, and lengthen the run every second turn
        if (walk_steps == '0) begin
          walk_turns = walk_turns - ssg_pkg::TURN_W'(1);
          if (walk_turns == '0) begin
            walk_run   = walk_run + ssg_pkg::DIM_W'(1);
            walk_turns = ssg_pkg::TURNS_PER_RUN;
          end
          walk_steps = walk_run;
          if (walk_rot == ssg_pkg::ROT_CCW) walk_heading = walk_heading - ssg_pkg::DIR_W'(1);
          else walk_heading = walk_heading + ssg_pkg::DIR_W'(1);
        end
      end
    end
  endtask

  task automatic check_field(input string field, input logic [ssg_pkg::NUM_W-1:0] want,
                             input logic [ssg_pkg::NUM_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Follow writes, requests and results on each rising edge
  always @(posedge clk) begin
    bit               emitted;
    ssg_pkg::result_t next_res;
    ssg_pkg::result_t want;
    if (!rst_n) begin
      side_reg      = ssg_pkg::DIM_W'(1);
      start_dir_reg = ssg_pkg::DIR_UP;
      rot_reg       = ssg_pkg::ROT_CW;
      walk_row      = '0;
      walk_col      = '0;
      walk_number   = '0;
      walk_run      = ssg_pkg::DIM_W'(1);
      walk_steps    = ssg_pkg::DIM_W'(1);
      walk_turns    = ssg_pkg::TURNS_PER_RUN;
      walk_heading  = ssg_pkg::DIR_UP;
      walk_on       = 1'b0;
      walk_rot      = ssg_pkg::ROT_CW;
      walk_cells    = ssg_pkg::SQ_W'(1);
      mismatches    = 0;
      due_cells.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ssg_pkg::CFG_DIMENSION: side_reg      = cfg_wdata;
          ssg_pkg::CFG_START_DIR: start_dir_reg = cfg_wdata[ssg_pkg::DIR_W-1:0];
          ssg_pkg::CFG_ROTATION:  rot_reg       = cfg_wdata[0];
          default:                ;
        endcase
      end
      if (in_valid && !in_stall) begin
        spiral_step(in_restart, emitted, next_res);
        if (emitted) due_cells.push_back(next_res);
      end
      if (out_valid && !out_stall) begin
        if (due_cells.size() == 0) begin
          $error("unexpected result: row %0d col %0d number %0d last %0b",
                 out_row, out_col, out_number, out_last);
          mismatches++;
        end else begin
          want = due_cells.pop_front();
          check_field("row", ssg_pkg::NUM_W'(want.row), ssg_pkg::NUM_W'(out_row));
          check_field("col", ssg_pkg::NUM_W'(want.col), ssg_pkg::NUM_W'(out_col));
          check_field("number", want.number, out_number);
          check_field("last", ssg_pkg::NUM_W'(want.last), ssg_pkg::NUM_W'(out_last));
        end
      end
    end
    cells_due = due_cells.size();
  end

endmodule

// File: verif/tb_spiral_scan_generator_top.sv
// ----------------------------------------------------------------------------
// tb_spiral_scan_generator_top
// Stimulus and verdict for the spiral scan generator.
//
// Drives restart and advance requests in bursts with random gaps while the
// result side stalls on its own pattern, once holding off long enough to back
// the block up. A short directed opening covers the grid size limits, idle
// advances, restarts mid-walk and register changes mid-walk; random phases
// then run mostly whole walks over varied sizes, start headings and turn
// senses, plus one full walk of the largest grid. Checking sits in
// spiral_walk_checker.
// ----------------------------------------------------------------------------
module tb_spiral_scan_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int CELL_BUDGET   = 1700;
  localparam int GRID_MAX      = ssg_pkg::MAX_DIM_DEF;

  // Index with no register behind it
  localparam logic [ssg_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_restart;
  logic                          out_valid;
  logic                          out_stall;
  logic [ssg_pkg::ROW_W-1:0]     out_row;
  logic [ssg_pkg::ROW_W-1:0]     out_col;
  logic [ssg_pkg::NUM_W-1:0]     out_number;
  logic                          out_last;
  logic                          cfg_we;
  logic [ssg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ssg_pkg::DIM_W-1:0]     cfg_wdata;

  int mismatches;
  int cells_due;
  int idle_cycles = 0;
  int burst_left;
  int walk_left;
  int cells_sent;
  logic [ssg_pkg::DIM_W-1:0] side_now;
  bit hold_off_req = 1'b0;

  spiral_scan_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_number (out_number),
    .out_last   (out_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  spiral_walk_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_number (out_number),
    .out_last   (out_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .cells_due  (cells_due)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // End the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: stall in stretches of varying density, with one long hold-off
  initial begin : result_side
    int stretch;
    int stall_pct;
    out_stall = 1'b0;
    forever begin
      stretch = $urandom_range(10, 80);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat (stretch) begin
        @(negedge clk);
        if (hold_off_req) begin
          out_stall <= 1'b1;
          repeat (HOLD_OFF_CYCLES) @(negedge clk);
          hold_off_req = 1'b0;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic int grid_side(input logic [ssg_pkg::DIM_W-1:0] dim);
    if (dim == 0) return 1;
    if (dim > GRID_MAX) return GRID_MAX;
    return int'(dim);
  endfunction

  // Offer one request, opening a new burst after a random gap when due
  task automatic send_request(input logic restart_bit);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_restart <= restart_bit;
    burst_left--;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    // Count only requests that give a cell
    if (restart_bit) walk_left = grid_side(side_now) * grid_side(side_now);
    if (walk_left > 0) begin
      walk_left--;
      cells_sent++;
    end
  endtask

  // Stop offering and wait until every cell owed has come out
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (cells_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [ssg_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ssg_pkg::DIM_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  // Write all registers while the block is idle
  task automatic configure(input logic [ssg_pkg::DIM_W-1:0] dim,
                           input logic [ssg_pkg::DIM_W-1:0] dir_data,
                           input logic [ssg_pkg::DIM_W-1:0] rot_data,
                           input bit touch_spare);
    drain();
    write_register(ssg_pkg::CFG_DIMENSION, dim);
    write_register(ssg_pkg::CFG_START_DIR, dir_data);
    write_register(ssg_pkg::CFG_ROTATION, rot_data);
    if (touch_spare) write_register(CFG_SPARE, ssg_pkg::DIM_W'($urandom_range(0, 63)));
    cfg_we   <= 1'b0;
    side_now = dim;
  endtask

  initial begin : stimulus
    logic [ssg_pkg::DIM_W-1:0] dim;
    int pick;
    int side;
    int advances;
    bit long_walk_done;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_restart = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = ssg_pkg::CFG_DIMENSION;
    cfg_wdata  = '0;
    burst_left = 0;
    walk_left  = 0;
    cells_sent = 0;
    side_now   = ssg_pkg::DIM_W'(1);
    long_walk_done = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Idle after reset, single-cell grid, idle after the last cell
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);

    // Zero side acts as one; the spare index is ignored
    configure(6'd0, {4'b1111, ssg_pkg::DIR_UP}, {5'b11111, ssg_pkg::ROT_CW}, 1'b1);
    send_request(1'b1);
    send_request(1'b0);

    // Side above the limit acts as the limit
    configure(6'd63, {4'b0000, ssg_pkg::DIR_LEFT}, {5'b00000, ssg_pkg::ROT_CCW}, 1'b0);
    send_request(1'b1);
    repeat (5) send_request(1'b0);

    // Change registers mid-walk: the old walk carries on until a restart
    configure(6'd2, {4'b1010, ssg_pkg::DIR_RIGHT}, {5'b10101, ssg_pkg::ROT_CW}, 1'b0);
    repeat (3) send_request(1'b0);
    send_request(1'b1);
    repeat (4) send_request(1'b0);

    // Restart during a walk
    configure(6'd3, {4'b0101, ssg_pkg::DIR_DOWN}, {5'b01010, ssg_pkg::ROT_CCW}, 1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);

    cells_sent = 0;
    while (cells_sent < CELL_BUDGET) begin
      // One full walk of the largest grid, with the result side held off
      if (!long_walk_done && cells_sent >= CELL_BUDGET / 4) begin
        configure(ssg_pkg::DIM_W'(GRID_MAX), ssg_pkg::DIM_W'($urandom_range(0, 63)),
                  ssg_pkg::DIM_W'($urandom_range(0, 63)), 1'b0);
        hold_off_req = 1'b1;
        send_request(1'b1);
        repeat (GRID_MAX * GRID_MAX) send_request(1'b0);
        long_walk_done = 1'b1;
      end

      pick = $urandom_range(0, 39);
      if (pick == 0) dim = '0;
      else if (pick == 1) dim = ssg_pkg::DIM_W'($urandom_range(GRID_MAX + 1, 63));
      else if (pick < 6) dim = ssg_pkg::DIM_W'($urandom_range(9, 16));
      else dim = ssg_pkg::DIM_W'($urandom_range(1, 8));
      configure(dim, ssg_pkg::DIM_W'($urandom_range(0, 63)),
                ssg_pkg::DIM_W'($urandom_range(0, 63)), $urandom_range(0, 19) == 0);
      side = grid_side(dim);

      if ($urandom_range(0, 9) < 8) begin
        // Whole walks, sometimes cut short or run past the last cell
        repeat ($urandom_range(1, 3)) begin
          send_request(1'b1);
          advances = side * side - 1;
          if (dim > GRID_MAX) advances = $urandom_range(0, 60);
          else if ($urandom_range(0, 9) == 0) advances = $urandom_range(0, advances);
          repeat (advances) send_request(1'b0);
          if ($urandom_range(0, 3) == 0) send_request(1'b0);
        end
      end else begin
        // Noise: sparse restarts among advances
        repeat ($urandom_range(1, 30)) send_request($urandom_range(0, 7) == 0);
      end
    end

    drain();
    if (mismatches == 0 && cells_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
